### rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV/HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CH_W     = 8;
  localparam int HUE_FRAC = 6;
  localparam int HUE_W    = 15;
  localparam int HQ_W     = 12;                  // hue quotient bits, covers HUE_UNIT
  localparam int HN_W     = HQ_W + CH_W;         // hue numerator bits
  localparam int SQ_W     = CH_W;                // saturation quotient bits
  localparam int SN_W     = 2 * CH_W;            // saturation numerator bits

  localparam logic [HUE_W-1:0] HUE_UNIT = HUE_W'(60 << HUE_FRAC);
  localparam logic [HUE_W-1:0] HUE_TURN = HUE_W'(6 * (60 << HUE_FRAC));
  localparam logic [CH_W-1:0]  FULL     = {CH_W{1'b1}};

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [HN_W-1:0] hue_rem;
    logic [CH_W-1:0] hue_den;
    logic            neg;
    sector_t         sector;
    logic [SN_W-1:0] sat_rem;
    logic [CH_W-1:0] sat_den;
    logic [CH_W-1:0] bri;
    logic            achrom;
  } work_t;

  typedef struct packed {
    work_t           w;
    logic [HQ_W-1:0] q_h;
    logic [SQ_W-1:0] q_s;
  } stage_t;

endpackage

### rtl/rhc_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pixel_if / rhc_hsx_if
// Valid/ready channels for RGB pixels in and HSV/HSL results out.
// ----------------------------------------------------------------------------
interface rhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsx_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        achromatic;
  modport source (output valid, hue, saturation, brightness, achromatic, input ready);
  modport sink   (input valid, hue, saturation, brightness, achromatic, output ready);
endinterface

### rtl/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// Finds max/min, hue sector and divider operands; one registered stage.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           mode,
  rhc_pixel_if.sink      pixel,
  output logic           fvalid,
  input  logic           fready,
  output rhc_pkg::work_t fwork
);

  logic [rhc_pkg::CH_W-1:0] mx, mn, delta, absdiff, den;
  logic [rhc_pkg::CH_W:0]   sum;
  logic signed [rhc_pkg::CH_W:0] diff;
  rhc_pkg::sector_t         sector;
  rhc_pkg::work_t           work_next;

  assign pixel.ready = !fvalid || fready;

  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    if (pixel.red >= mx) begin
      sector = rhc_pkg::SECT_RED;
      diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
    end else if (pixel.green >= mx) begin
      sector = rhc_pkg::SECT_GREEN;
      diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
    end else begin
      sector = rhc_pkg::SECT_BLUE;
      diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
    end
    absdiff = diff[rhc_pkg::CH_W] ? rhc_pkg::CH_W'(-diff) : diff[rhc_pkg::CH_W-1:0];
    if (!mode) begin
      den = mx;
    end else if (sum < {1'b0, rhc_pkg::FULL}) begin
      den = sum[rhc_pkg::CH_W-1:0];
    end else begin
      den = rhc_pkg::CH_W'({rhc_pkg::FULL, 1'b0} - sum);
    end
    work_next.hue_rem = rhc_pkg::HN_W'(absdiff) * rhc_pkg::HN_W'(rhc_pkg::HUE_UNIT);
    work_next.hue_den = delta;
    work_next.neg     = diff[rhc_pkg::CH_W];
    work_next.sector  = sector;
    work_next.sat_rem = ({delta, {rhc_pkg::CH_W{1'b0}}}) - rhc_pkg::SN_W'(delta);
    work_next.sat_den = den;
    work_next.bri     = mode ? sum[rhc_pkg::CH_W:1] : mx;
    work_next.achrom  = (delta == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (pixel.ready) begin
      fvalid <= pixel.valid;
    end
    if (pixel.ready && pixel.valid) begin
      fwork <= work_next;
    end
  end

endmodule

### rtl/rhc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_queue
// Two-entry queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module rhc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rhc_pkg::work_t push_work,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rhc_pkg::work_t pop_work
);

  rhc_pkg::work_t entry [2];
  logic           wptr, rptr;
  logic [1:0]     count;
  logic           push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_work   = entry[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      entry[wptr] <= push_work;
    end
  end

endmodule

### rtl/rhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back
// Pipelined restoring dividers for hue and saturation, one hue quotient bit
// per stage, followed by the hue fix-up and the output register.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rhc_pkg::work_t in_work,
  rhc_hsx_if.source      result
);

  localparam int NST = rhc_pkg::HQ_W;

  rhc_pkg::stage_t st [NST];
  rhc_pkg::stage_t st_next [NST];
  logic [NST-1:0]  vld;
  logic [NST-1:0]  adv;
  logic            adv_o;

  logic [rhc_pkg::HUE_W-1:0] offset, base, q_ext, hue_next;
  rhc_pkg::stage_t           last;

  assign adv_o    = !result.valid || result.ready;
  assign in_ready = adv[0];

  always_comb begin
    adv[NST-1] = !vld[NST-1] || adv_o;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    localparam int K = NST - 1 - i;
    rhc_pkg::stage_t src;
    logic [rhc_pkg::HN_W-1:0] dh;
    logic [rhc_pkg::SN_W-1:0] ds;

    if (i == 0) begin : g_first
      always_comb begin
        src     = '0;
        src.w   = in_work;
      end
    end else begin : g_rest
      assign src = st[i-1];
    end

    always_comb begin
      st_next[i] = src;
      dh = rhc_pkg::HN_W'(src.w.hue_den) << K;
      if (src.w.hue_rem >= dh) begin
        st_next[i].w.hue_rem = src.w.hue_rem - dh;
        st_next[i].q_h[K]    = 1'b1;
      end
      ds = '0;
      if (K < rhc_pkg::SQ_W) begin
        ds = rhc_pkg::SN_W'(src.w.sat_den) << K;
        if (src.w.sat_rem >= ds) begin
          st_next[i].w.sat_rem = src.w.sat_rem - ds;
          st_next[i].q_s[K % rhc_pkg::SQ_W] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv[i]) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i - 1];
      end
      if (adv[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  always_comb begin
    last  = st[NST-1];
    q_ext = rhc_pkg::HUE_W'(last.q_h);
    case (last.w.sector)
      rhc_pkg::SECT_GREEN: offset = rhc_pkg::HUE_W'(2 * rhc_pkg::HUE_UNIT);
      rhc_pkg::SECT_BLUE:  offset = rhc_pkg::HUE_W'(4 * rhc_pkg::HUE_UNIT);
      default:             offset = '0;
    endcase
    base = (last.w.sector == rhc_pkg::SECT_RED && last.q_h != '0) ?
           rhc_pkg::HUE_TURN : offset;
    hue_next = last.w.neg ? base - q_ext : offset + q_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv_o) begin
      result.valid <= vld[NST-1];
    end
    if (adv_o && vld[NST-1]) begin
      result.hue        <= last.w.achrom ? '0 : hue_next;
      result.saturation <= last.w.achrom ? '0 : last.q_s;
      result.brightness <= last.w.bri;
      result.achromatic <= last.w.achrom;
    end
  end

endmodule

### rtl/rgb_to_hsv_hsl_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter
// A pixel passes the front register, the queue, 12 divider stages and the
// output register. Throughput: one pixel per cycle while the result side
// accepts results, set by the one-bit-per-stage divider pipeline. Synchronous
// reset clears all valid flags and the queue and selects HSV mode.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_converter (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  rhc_pixel_if.sink pixel,
  rhc_hsx_if.source result
);

  logic           mode;
  logic           fvalid, fready, qvalid, qready;
  rhc_pkg::work_t fwork, qwork;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  rhc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .mode   (mode),
    .pixel  (pixel),
    .fvalid (fvalid),
    .fready (fready),
    .fwork  (fwork)
  );

  rhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fvalid),
    .push_ready (fready),
    .push_work  (fwork),
    .pop_valid  (qvalid),
    .pop_ready  (qready),
    .pop_work   (qwork)
  );

  rhc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qvalid),
    .in_ready (qready),
    .in_work  (qwork),
    .result   (result)
  );

endmodule
